@@ hdl/dkf_pkg.sv @@
package dkf_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int CNT_W    = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } dkf_state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  wdata;
  } dkf_ram_req_t;

  typedef struct packed {
    logic              filter_on;
    logic [FILL_W-1:0] fill;
  } dkf_status_t;

endpackage

@@ hdl/dkf_if.sv @@
interface dkf_item_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] run_number;
  logic signed [31:0] event_number;
  logic               dataset_active;

  modport source(output valid, func, run_number, event_number, dataset_active,
                 input ready);
  modport sink(input valid, func, run_number, event_number, dataset_active,
               output ready);
endinterface

interface dkf_res_if;
  logic        valid;
  logic        ready;
  logic        is_duplicate;
  logic [31:0] duplicate_count;
  logic        store_full;

  modport source(output valid, is_duplicate, duplicate_count, store_full,
                 input ready);
  modport sink(input valid, is_duplicate, duplicate_count, store_full,
               output ready);
endinterface

@@ hdl/dkf_key_ram.sv @@
module dkf_key_ram (
  input  logic                      clk,
  input  dkf_pkg::dkf_ram_req_t     req,
  output logic [dkf_pkg::KEY_W-1:0] rdata
);

  logic [dkf_pkg::KEY_W-1:0] mem [dkf_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

@@ hdl/dkf_ctrl.sv @@
module dkf_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  dkf_item_if.sink                  item,
  dkf_res_if.source                 result,
  output dkf_pkg::dkf_ram_req_t     ram_req,
  input  logic [dkf_pkg::KEY_W-1:0] ram_rdata,
  output dkf_pkg::dkf_status_t      status
);

  localparam logic [dkf_pkg::FILL_W-1:0] CAP = dkf_pkg::FILL_W'(dkf_pkg::CAPACITY);

  dkf_pkg::dkf_state_t             state;
  dkf_pkg::dkf_state_t             state_next;
  logic [dkf_pkg::ADDR_W-1:0]      idx;
  logic [dkf_pkg::FILL_W-1:0]      fill;
  logic [dkf_pkg::CNT_W-1:0]       cnt;
  logic                            filter_on;
  logic [dkf_pkg::KEY_W-1:0]       key;
  logic                            pend;
  logic                            hit;
  logic                            dup;

  logic accept;
  logic key_eq;
  logic hit_final;
  logic last_issue;
  logic has_room;
  logic out_free;

  assign accept     = item.valid && item.ready;
  assign key_eq     = (ram_rdata == key);
  assign hit_final  = hit || (pend && key_eq);
  assign last_issue = (dkf_pkg::FILL_W'(idx) == (fill - dkf_pkg::FILL_W'(1)));
  assign has_room   = (fill < CAP);
  assign out_free   = !result.valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      dkf_pkg::ST_IDLE: begin
        if (accept) begin
          if (item.func || !filter_on) begin
            state_next = dkf_pkg::ST_DONE;
          end else if (fill == '0) begin
            state_next = dkf_pkg::ST_DRAIN;
          end else begin
            state_next = dkf_pkg::ST_SCAN;
          end
        end
      end
      dkf_pkg::ST_SCAN: begin
        if (last_issue) begin
          state_next = dkf_pkg::ST_DRAIN;
        end
      end
      dkf_pkg::ST_DRAIN: begin
        state_next = dkf_pkg::ST_DONE;
      end
      dkf_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = dkf_pkg::ST_IDLE;
        end
      end
      default: state_next = dkf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready    = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.addr  = idx;
    ram_req.wdata = key;
    unique case (state)
      dkf_pkg::ST_IDLE:  item.ready = 1'b1;
      dkf_pkg::ST_SCAN:  ram_req.addr = idx;
      dkf_pkg::ST_DRAIN: begin
        ram_req.we   = !hit_final && has_room;
        ram_req.addr = fill[dkf_pkg::ADDR_W-1:0];
      end
      dkf_pkg::ST_DONE:  ram_req.we = 1'b0;
      default:           ram_req.we = 1'b0;
    endcase
  end

  assign status.filter_on = filter_on;
  assign status.fill      = fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dkf_pkg::ST_IDLE;
      idx          <= '0;
      fill         <= '0;
      cnt          <= '0;
      filter_on    <= 1'b1;
      pend         <= 1'b0;
      hit          <= 1'b0;
      dup          <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == dkf_pkg::ST_SCAN);
      if (pend && key_eq) begin
        hit <= 1'b1;
      end
      if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        dkf_pkg::ST_IDLE: begin
          if (accept) begin
            key <= {item.run_number, item.event_number};
            idx <= '0;
            hit <= 1'b0;
            dup <= 1'b0;
            if (item.func) begin
              fill      <= '0;
              cnt       <= '0;
              filter_on <= item.dataset_active;
            end
          end
        end
        dkf_pkg::ST_SCAN: begin
          idx <= idx + dkf_pkg::ADDR_W'(1);
        end
        dkf_pkg::ST_DRAIN: begin
          if (hit_final) begin
            dup <= 1'b1;
            if (cnt != '1) begin
              cnt <= cnt + dkf_pkg::CNT_W'(1);
            end
          end else if (has_room) begin
            fill <= fill + dkf_pkg::FILL_W'(1);
          end
        end
        dkf_pkg::ST_DONE: begin
          if (out_free) begin
            result.valid           <= 1'b1;
            result.is_duplicate    <= dup;
            result.duplicate_count <= cnt;
            result.store_full      <= !has_room;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/duplicate_key_filter_unit.sv @@
// channel  dir  modport  word
// item     in   sink     func, run_number, event_number, dataset_active
// result   out  source   is_duplicate, duplicate_count, store_full
//
// A boundary item or an event while filtering is off goes straight to the result, with no key scan.
// An event scans every stored key through the single-port key memory, read
// once per cycle against the one key comparator.
// rst is synchronous: store empty, count zero, filtering on; memory unswept.
// A result waiting on result.ready does not block the next item's scan.
module duplicate_key_filter_unit (
  input  logic      clk,
  input  logic      rst,
  dkf_item_if.sink  item,
  dkf_res_if.source result
);

  dkf_pkg::dkf_ram_req_t     ram_req;
  logic [dkf_pkg::KEY_W-1:0] ram_rdata;
  dkf_pkg::dkf_status_t      status;

  dkf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .status    (status)
  );

  dkf_key_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  a_write_has_room: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (status.fill < dkf_pkg::FILL_W'(dkf_pkg::CAPACITY)))
    else $error("key write with store full");

  a_write_when_filtering: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> status.filter_on)
    else $error("key write while filtering off");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> !ram_req.we)
    else $error("key write while accepting");

  a_dup_counted: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.is_duplicate) |-> (result.duplicate_count != '0))
    else $error("duplicate flagged with zero count");

endmodule
